[hw/rtl/umf_pkg.sv]
// Shared types and codes for the unit-augment max-flow engine.
package umf_pkg;

   localparam int NODE_W   = 13;
   localparam int CAP_IN_W = 4;
   localparam int CNT_W    = 14;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_AUG = 2'd1;
   localparam logic [1:0] KIND_QRY = 2'd2;
   localparam logic [1:0] KIND_CLR = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOPATH = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_BAD    = 2'd3;

   localparam logic [15:0] MARK_NEVER = 16'hFFFF;

   typedef struct packed {
      logic [1:0]          kind;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [CAP_IN_W-1:0] edge_capacity;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [CAP_IN_W-1:0] flow_amount;
   } rsp_type;

endpackage

[hw/rtl/umf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module umf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/unit_augment_max_flow_engine.sv]
// Max-flow engine top level: edge table, adjacency lists and BFS sequencer.
// Transfers are taken one at a time; a rejected add does not go busy. A query walks
// the adjacency slots of node_a; an augment dequeues nodes, scans their incident slots
// and walks the found path back. Reset and clear sweep every entry of the node
// memories (busy high); a round wrap sweeps only the mark memory before the search.
// Results are a one-cycle strobe; the receiver cannot stall.
module unit_augment_max_flow_engine #(
   parameter int MAX_NODES = 8192,
   parameter int MAX_EDGES = 16384,
   parameter int CAP_BITS  = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  umf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output umf_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [umf_pkg::CNT_W-1:0]      csr_wr_data
);

   localparam int NW      = $clog2(MAX_NODES);
   localparam int EW      = $clog2(MAX_EDGES);
   localparam int SW      = EW + 1;
   localparam int CW      = CAP_BITS;
   localparam int QW      = NW + 1;
   localparam int TW      = EW + 1;
   localparam int LW      = 18;
   localparam int CAP_MAX = (1 << CAP_BITS) - 1;
   localparam int EDGE_W  = 2 * NW + 2 * CW;

   typedef struct packed {
      logic [NW-1:0] tail;
      logic [NW-1:0] head;
      logic [CW-1:0] room;
      logic [CW-1:0] carried;
   } edge_type;

   typedef struct packed {
      logic          nil;
      logic [SW-1:0] slot;
   } link_type;

   typedef struct packed {
      logic          nil;
      logic [SW-1:0] first;
      logic [SW-1:0] last;
   } list_type;

   typedef enum logic [1:0] {
      SWP_RESET,
      SWP_CLEAR,
      SWP_WRAP
   } sweep_type;

   typedef enum logic [4:0] {
      S_SWEEP, S_IDLE, S_ADD_A, S_ADD_AW, S_ADD_B, S_ADD_BW,
      S_QRY_L, S_QRY_S, S_QRY_SW, S_AUG_INIT, S_DEQ, S_DEQ_W, S_LST,
      S_SLOT, S_SLOT_W, S_MRK, S_CHK, S_BT, S_BT_A, S_BT_E
   } state_type;

   state_type               state_ff, state_in;
   sweep_type               swp_ff, swp_in;
   logic [NW-1:0]           sweep_ff, sweep_in;
   umf_pkg::req_type        req_ff, req_in;
   logic [umf_pkg::CNT_W-1:0] ncnt_ff, ncnt_in;
   logic [TW-1:0]           total_ff, total_in;
   logic [15:0]             round_ff, round_in;
   logic [QW-1:0]           qh_ff, qh_in, qt_ff, qt_in, steps_ff, steps_in;
   logic [NW-1:0]           f_ff, f_in, nb_ff, nb_in, back_ff, back_in;
   logic [SW-1:0]           slot_ff, slot_in;
   link_type                nxt_ff, nxt_in;
   logic [EW-1:0]           e_ff, e_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   umf_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    edge_we, next_we, list_we, mark_we, arr_we, queue_we;
   logic [EW-1:0]           edge_wa, edge_ra;
   edge_type                edge_wd, edge_rd;
   logic [SW-1:0]           next_wa, next_ra;
   link_type                next_wd, next_rd;
   logic [NW-1:0]           list_wa, list_ra, mark_wa, mark_ra, arr_wa, arr_ra;
   list_type                list_wd, list_rd;
   logic [15:0]             mark_wd, mark_rd;
   logic [EW-1:0]           arr_wd, arr_rd;
   logic [NW-1:0]           queue_wa, queue_ra, queue_wd, queue_rd;

   logic [LW-1:0]           lim;
   logic                    bad_node;
   logic [NW-1:0]           na, nb_req;
   logic [CW-1:0]           cap_sat;
   logic [15:0]             round_next;
   logic                    open_e;
   logic [NW-1:0]           other_n;

   umf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd));
   umf_ram #(.WIDTH(SW + 1), .DEPTH(2 * MAX_EDGES)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(next_ra), .rd_data(next_rd));
   umf_ram #(.WIDTH(2 * SW + 1), .DEPTH(MAX_NODES)) u_list (
      .clock(clock), .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
      .rd_addr(list_ra), .rd_data(list_rd));
   umf_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_mark (
      .clock(clock), .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
      .rd_addr(mark_ra), .rd_data(mark_rd));
   umf_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_arr (
      .clock(clock), .wr_en(arr_we), .wr_addr(arr_wa), .wr_data(arr_wd),
      .rd_addr(arr_ra), .rd_data(arr_rd));
   umf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .wr_en(queue_we), .wr_addr(queue_wa), .wr_data(queue_wd),
      .rd_addr(queue_ra), .rd_data(queue_rd));

   always_comb begin
      lim = LW'(ncnt_ff);
      if (lim < LW'(2)) begin
         lim = LW'(2);
      end
      if (lim > LW'(MAX_NODES)) begin
         lim = LW'(MAX_NODES);
      end
   end

   assign bad_node = (LW'(req_data.node_a) >= lim) || (LW'(req_data.node_b) >= lim);
   assign na       = NW'(req_ff.node_a);
   assign nb_req   = NW'(req_ff.node_b);
   assign cap_sat  = (LW'(req_ff.edge_capacity) > LW'(CAP_MAX)) ? CW'(CAP_MAX)
                                                                 : CW'(req_ff.edge_capacity);
   assign round_next = round_ff + 16'd1;
   assign open_e  = (f_ff == edge_rd.tail) ? (edge_rd.room != '0) : (edge_rd.carried != '0);
   assign other_n = (f_ff == edge_rd.head) ? edge_rd.tail : edge_rd.head;

   always_comb begin
      state_in     = state_ff;
      swp_in       = swp_ff;
      sweep_in     = sweep_ff;
      req_in       = req_ff;
      ncnt_in      = ncnt_ff;
      total_in     = total_ff;
      round_in     = round_ff;
      qh_in        = qh_ff;
      qt_in        = qt_ff;
      steps_in     = steps_ff;
      f_in         = f_ff;
      nb_in        = nb_ff;
      back_in      = back_ff;
      slot_in      = slot_ff;
      nxt_in       = nxt_ff;
      e_in         = e_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
      list_we = 1'b0; list_wa = '0; list_wd = '0; list_ra = '0;
      mark_we = 1'b0; mark_wa = '0; mark_wd = '0; mark_ra = '0;
      arr_we  = 1'b0; arr_wa  = '0; arr_wd  = '0; arr_ra  = '0;
      queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_ra = '0;

      if (csr_wr_en) begin
         ncnt_in = csr_wr_data;
      end

      case (state_ff)
         S_SWEEP: begin
            mark_we = 1'b1;
            mark_wa = sweep_ff;
            mark_wd = umf_pkg::MARK_NEVER;
            if (swp_ff != SWP_WRAP) begin
               list_we = 1'b1;
               list_wa = sweep_ff;
               list_wd = '{nil: 1'b1, first: '0, last: '0};
            end
            sweep_in = sweep_ff + NW'(1);
            if (sweep_ff == NW'(MAX_NODES - 1)) begin
               sweep_in = '0;
               round_in = '0;
               case (swp_ff)
                  SWP_WRAP: begin
                     state_in = S_AUG_INIT;
                  end
                  SWP_CLEAR: begin
                     total_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: umf_pkg::STAT_OK, flow_amount: '0};
                     state_in     = S_IDLE;
                  end
                  default: begin
                     total_in = '0;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.kind)
                  umf_pkg::KIND_ADD: begin
                     if (bad_node) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: umf_pkg::STAT_BAD, flow_amount: '0};
                     end else if (total_ff == TW'(MAX_EDGES)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: umf_pkg::STAT_FULL, flow_amount: '0};
                     end else begin
                        state_in = S_ADD_A;
                     end
                  end
                  umf_pkg::KIND_AUG: begin
                     if (round_next == umf_pkg::MARK_NEVER) begin
                        swp_in   = SWP_WRAP;
                        state_in = S_SWEEP;
                     end else begin
                        round_in = round_next;
                        state_in = S_AUG_INIT;
                     end
                  end
                  umf_pkg::KIND_QRY: begin
                     if (bad_node) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: umf_pkg::STAT_BAD, flow_amount: '0};
                     end else begin
                        list_ra  = NW'(req_data.node_a);
                        state_in = S_QRY_L;
                     end
                  end
                  default: begin
                     swp_in   = SWP_CLEAR;
                     state_in = S_SWEEP;
                  end
               endcase
            end
         end
         S_ADD_A: begin
            edge_we = 1'b1;
            edge_wa = total_ff[EW-1:0];
            edge_wd = '{tail: na, head: nb_req, room: cap_sat, carried: '0};
            next_we = 1'b1;
            next_wa = {total_ff[EW-1:0], 1'b0};
            next_wd = '{nil: 1'b1, slot: '0};
            list_ra = na;
            state_in = S_ADD_AW;
         end
         S_ADD_AW, S_ADD_BW: begin
            slot_in = {total_ff[EW-1:0], (state_ff == S_ADD_BW)};
            list_we = 1'b1;
            list_wa = (state_ff == S_ADD_BW) ? nb_req : na;
            if (list_rd.nil) begin
               list_wd = '{nil: 1'b0, first: slot_in, last: slot_in};
            end else begin
               list_wd = '{nil: 1'b0, first: list_rd.first, last: slot_in};
               next_we = 1'b1;
               next_wa = list_rd.last;
               next_wd = '{nil: 1'b0, slot: slot_in};
            end
            if (state_ff == S_ADD_BW) begin
               total_in     = total_ff + TW'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: umf_pkg::STAT_OK, flow_amount: '0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_ADD_B;
            end
         end
         S_ADD_B: begin
            next_we  = 1'b1;
            next_wa  = {total_ff[EW-1:0], 1'b1};
            next_wd  = '{nil: 1'b1, slot: '0};
            list_ra  = nb_req;
            state_in = S_ADD_BW;
         end
         S_QRY_L: begin
            if (list_rd.nil) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{status: umf_pkg::STAT_OK, flow_amount: '0};
               state_in = S_IDLE;
            end else begin
               slot_in  = list_rd.first;
               state_in = S_QRY_S;
            end
         end
         S_QRY_S, S_SLOT: begin
            edge_ra  = slot_ff[SW-1:1];
            next_ra  = slot_ff;
            state_in = (state_ff == S_QRY_S) ? S_QRY_SW : S_SLOT_W;
         end
         S_QRY_SW: begin
            if (edge_rd.tail == na && edge_rd.head == nb_req) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{status: umf_pkg::STAT_OK,
                            flow_amount: umf_pkg::CAP_IN_W'(edge_rd.carried)};
               state_in = S_IDLE;
            end else if (next_rd.nil) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{status: umf_pkg::STAT_OK, flow_amount: '0};
               state_in = S_IDLE;
            end else begin
               slot_in  = next_rd.slot;
               state_in = S_QRY_S;
            end
         end
         S_AUG_INIT: begin
            queue_we = 1'b1;
            queue_wa = '0;
            queue_wd = '0;
            mark_we  = 1'b1;
            mark_wa  = '0;
            mark_wd  = round_ff;
            qh_in    = '0;
            qt_in    = QW'(1);
            state_in = S_DEQ;
         end
         S_DEQ: begin
            if (qh_ff == qt_ff) begin
               mark_ra  = NW'(1);
               state_in = S_CHK;
            end else begin
               queue_ra = qh_ff[NW-1:0];
               qh_in    = qh_ff + QW'(1);
               state_in = S_DEQ_W;
            end
         end
         S_DEQ_W: begin
            f_in = queue_rd;
            if (queue_rd == NW'(1)) begin
               mark_ra  = NW'(1);
               state_in = S_CHK;
            end else begin
               list_ra  = queue_rd;
               state_in = S_LST;
            end
         end
         S_LST: begin
            if (list_rd.nil) begin
               state_in = S_DEQ;
            end else begin
               slot_in  = list_rd.first;
               state_in = S_SLOT;
            end
         end
         S_SLOT_W: begin
            nxt_in = next_rd;
            if (open_e) begin
               mark_ra  = other_n;
               nb_in    = other_n;
               state_in = S_MRK;
            end else if (next_rd.nil) begin
               state_in = S_DEQ;
            end else begin
               slot_in  = next_rd.slot;
               state_in = S_SLOT;
            end
         end
         S_MRK: begin
            if (mark_rd != round_ff && qt_ff < QW'(MAX_NODES)) begin
               mark_we  = 1'b1;
               mark_wa  = nb_ff;
               mark_wd  = round_ff;
               arr_we   = 1'b1;
               arr_wa   = nb_ff;
               arr_wd   = slot_ff[SW-1:1];
               queue_we = 1'b1;
               queue_wa = qt_ff[NW-1:0];
               queue_wd = nb_ff;
               qt_in    = qt_ff + QW'(1);
            end
            if (nxt_ff.nil) begin
               state_in = S_DEQ;
            end else begin
               slot_in  = nxt_ff.slot;
               state_in = S_SLOT;
            end
         end
         S_CHK: begin
            if (mark_rd != round_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{status: umf_pkg::STAT_NOPATH, flow_amount: '0};
               state_in = S_IDLE;
            end else begin
               back_in  = NW'(1);
               steps_in = '0;
               state_in = S_BT;
            end
         end
         S_BT: begin
            if (back_ff == '0 || steps_ff == QW'(MAX_NODES)) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{status: umf_pkg::STAT_OK, flow_amount: '0};
               state_in = S_IDLE;
            end else begin
               arr_ra   = back_ff;
               state_in = S_BT_A;
            end
         end
         S_BT_A: begin
            e_in     = arr_rd;
            edge_ra  = arr_rd;
            state_in = S_BT_E;
         end
         S_BT_E: begin
            edge_we = 1'b1;
            edge_wa = e_ff;
            edge_wd = edge_rd;
            back_in = (back_ff == edge_rd.head) ? edge_rd.tail : edge_rd.head;
            if (back_in == edge_rd.tail) begin
               edge_wd.room    = edge_rd.room - CW'(1);
               edge_wd.carried = edge_rd.carried + CW'(1);
            end else begin
               edge_wd.carried = edge_rd.carried - CW'(1);
               edge_wd.room    = edge_rd.room + CW'(1);
            end
            steps_in = steps_ff + QW'(1);
            state_in = S_BT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         swp_ff       <= SWP_RESET;
         sweep_ff     <= '0;
         ncnt_ff      <= umf_pkg::CNT_W'(8192);
         total_ff     <= '0;
         round_ff     <= '0;
         qh_ff        <= '0;
         qt_ff        <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         swp_ff       <= swp_in;
         sweep_ff     <= sweep_in;
         ncnt_ff      <= ncnt_in;
         total_ff     <= total_in;
         round_ff     <= round_in;
         qh_ff        <= qh_in;
         qt_ff        <= qt_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      f_ff    <= f_in;
      nb_ff   <= nb_in;
      back_ff <= back_in;
      slot_ff <= slot_in;
      nxt_ff  <= nxt_in;
      e_ff    <= e_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(MAX_EDGES))
      else $error("edge count beyond table size");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      qh_ff <= qt_ff && qt_ff <= QW'(MAX_NODES))
      else $error("search queue pointers out of order");

endmodule

[test/testbench.sv]
// Testbench for unit_augment_max_flow_engine: random and directed graph commands.
module testbench;

   localparam int NODES = 8192;
   localparam int EDGES = 16384;
   localparam int unsigned NONE = 32'hFFFF_FFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   umf_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   umf_pkg::rsp_type          rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [umf_pkg::CNT_W-1:0] csr_wr_data = '0;

   unit_augment_max_flow_engine i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // flow graph model
   int unsigned e_tail [EDGES];
   int unsigned e_head [EDGES];
   int unsigned e_room [EDGES];
   int unsigned e_carry[EDGES];
   int unsigned e_total;
   int unsigned mark   [NODES];
   int unsigned via    [NODES];
   int unsigned bfs_q  [NODES];
   int unsigned round_no;
   int unsigned adj_first[NODES];
   int unsigned adj_last [NODES];
   int unsigned adj_next [2*EDGES];
   int unsigned node_cnt;

   umf_pkg::req_type pending_reqs[$];
   umf_pkg::rsp_type flow_expected[$];
   int      idle_pct = 0;
   int      errors = 0;

   function automatic int unsigned node_lim();
      if (node_cnt < 2) return 2;
      if (node_cnt > NODES) return NODES;
      return node_cnt;
   endfunction

   function automatic void graph_clear();
      e_total = 0;
      round_no = 0;
      for (int i = 0; i < NODES; i++) begin
         mark[i] = 16'hFFFF;
         adj_first[i] = NONE;
         adj_last[i] = NONE;
      end
   endfunction

   function automatic void adj_link(int unsigned n, int unsigned s);
      adj_next[s] = NONE;
      if (adj_first[n] == NONE) adj_first[n] = s;
      else adj_next[adj_last[n]] = s;
      adj_last[n] = s;
   endfunction

   function automatic int unsigned far_end(int unsigned e, int unsigned at);
      return (at == e_head[e]) ? e_tail[e] : e_head[e];
   endfunction

   function automatic logic [1:0] find_path_push();
      int unsigned qh, qt, f, s, e, nb, back, steps;
      bit open;
      qh = 0;
      qt = 0;
      round_no = (round_no + 1) & 16'hFFFF;
      if (round_no == 16'hFFFF) begin
         for (int i = 0; i < NODES; i++) mark[i] = 16'hFFFF;
         round_no = 0;
      end
      bfs_q[qt++] = 0;
      mark[0] = round_no;
      while (qh < qt) begin
         f = bfs_q[qh++];
         if (f == 1) break;
         for (s = adj_first[f]; s != NONE; s = adj_next[s]) begin
            e = s >> 1;
            open = (f == e_tail[e]) ? (e_room[e] > 0) : (e_carry[e] > 0);
            if (open) begin
               nb = far_end(e, f) % NODES;
               if (mark[nb] != round_no && qt < NODES) begin
                  mark[nb] = round_no;
                  via[nb] = e;
                  bfs_q[qt++] = nb;
               end
            end
         end
      end
      if (mark[1] != round_no) return umf_pkg::STAT_NOPATH;
      back = 1;
      for (steps = 0; back != 0 && steps < NODES; steps++) begin
         e = via[back % NODES] % EDGES;
         back = far_end(e, back);
         if (back == e_tail[e]) begin
            e_room[e] = (e_room[e] - 1) & 4'hF;
            e_carry[e] = (e_carry[e] + 1) & 4'hF;
         end else begin
            e_carry[e] = (e_carry[e] - 1) & 4'hF;
            e_room[e] = (e_room[e] + 1) & 4'hF;
         end
      end
      return umf_pkg::STAT_OK;
   endfunction

   function automatic umf_pkg::rsp_type flow_predict(umf_pkg::req_type r);
      umf_pkg::rsp_type o;
      int unsigned a, b, lim;
      o = '0;
      a = r.node_a;
      b = r.node_b;
      lim = node_lim();
      case (r.kind)
         umf_pkg::KIND_ADD: begin
            if (a >= lim || b >= lim) o.status = umf_pkg::STAT_BAD;
            else if (e_total >= EDGES) o.status = umf_pkg::STAT_FULL;
            else begin
               e_tail[e_total] = a;
               e_head[e_total] = b;
               e_room[e_total] = r.edge_capacity;
               e_carry[e_total] = 0;
               adj_link(a, 2*e_total);
               adj_link(b, 2*e_total + 1);
               e_total++;
            end
         end
         umf_pkg::KIND_AUG: o.status = find_path_push();
         umf_pkg::KIND_QRY: begin
            if (a >= lim || b >= lim) o.status = umf_pkg::STAT_BAD;
            else
               for (int unsigned s = adj_first[a]; s != NONE; s = adj_next[s])
                  if (e_tail[s>>1] == a && e_head[s>>1] == b) begin
                     o.flow_amount = umf_pkg::CAP_IN_W'(e_carry[s>>1]);
                     break;
                  end
         end
         default: graph_clear();
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) flow_expected = {flow_expected, flow_predict(req_data)};
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      umf_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (flow_expected.size() == 0) begin
            report_mismatch("unexpected transfer", int'(rsp_data), 0);
         end else begin
            want = flow_expected.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.flow_amount != want.flow_amount)
               report_mismatch("flow_amount", rsp_data.flow_amount, want.flow_amount);
         end
      end
   end

   function automatic void add_cmd(logic [1:0] k, int a, int b, int c);
      umf_pkg::req_type r;
      r.kind = k;
      r.node_a = umf_pkg::NODE_W'(a);
      r.node_b = umf_pkg::NODE_W'(b);
      r.edge_capacity = umf_pkg::CAP_IN_W'(c);
      pending_reqs = {pending_reqs, r};
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || start || flow_expected.size() > 0 || busy);
   endtask

   task automatic write_count(int v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= umf_pkg::CNT_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_cnt = v;
   endtask

   task automatic random_items(int n, int span);
      int k, a, b;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         a = ($urandom_range(15) == 0) ? $urandom_range(8191) : $urandom_range(span - 1);
         b = ($urandom_range(15) == 0) ? $urandom_range(8191) : $urandom_range(span - 1);
         if (k < 45) add_cmd(umf_pkg::KIND_ADD, a, b, $urandom_range(15));
         else if (k < 75) add_cmd(umf_pkg::KIND_AUG, 0, 0, 0);
         else if (k < 97) add_cmd(umf_pkg::KIND_QRY, a, b, 0);
         else add_cmd(umf_pkg::KIND_CLR, a, b, $urandom_range(15));
      end
   endtask

   initial begin
      node_cnt = 8192;
      graph_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, bad nodes, self loop, missing edge
      add_cmd(umf_pkg::KIND_ADD, 0, 2, 15);
      add_cmd(umf_pkg::KIND_ADD, 2, 1, 1);
      add_cmd(umf_pkg::KIND_ADD, 2, 2, 7);
      add_cmd(umf_pkg::KIND_ADD, 0, 8191, 0);
      add_cmd(umf_pkg::KIND_AUG, 0, 0, 0);
      add_cmd(umf_pkg::KIND_AUG, 8191, 8191, 15);
      add_cmd(umf_pkg::KIND_QRY, 0, 2, 0);
      add_cmd(umf_pkg::KIND_QRY, 2, 1, 0);
      add_cmd(umf_pkg::KIND_QRY, 1, 2, 0);
      add_cmd(umf_pkg::KIND_QRY, 8191, 0, 0);
      add_cmd(umf_pkg::KIND_ADD, 1, 0, 3);
      add_cmd(umf_pkg::KIND_ADD, 2, 0, 5);
      add_cmd(umf_pkg::KIND_AUG, 0, 0, 0);
      add_cmd(umf_pkg::KIND_CLR, 8191, 8191, 15);
      add_cmd(umf_pkg::KIND_QRY, 0, 2, 0);
      drain();
      write_count(2);
      add_cmd(umf_pkg::KIND_ADD, 0, 1, 4);
      add_cmd(umf_pkg::KIND_ADD, 0, 2, 4);
      add_cmd(umf_pkg::KIND_QRY, 2, 0, 0);
      add_cmd(umf_pkg::KIND_AUG, 0, 0, 0);
      add_cmd(umf_pkg::KIND_QRY, 0, 1, 0);
      drain();
      write_count(0);
      add_cmd(umf_pkg::KIND_ADD, 1, 2, 1);
      add_cmd(umf_pkg::KIND_QRY, 0, 1, 0);
      drain();
      write_count(16383);
      add_cmd(umf_pkg::KIND_ADD, 8191, 1, 2);
      add_cmd(umf_pkg::KIND_CLR, 0, 0, 0);
      drain();

      // random phases
      for (int p = 0; p < 4; p++) begin
         idle_pct = (p == 1) ? 87 : (p == 3) ? 16 : 0;
         write_count((p == 2) ? 8191 : $urandom_range(2, 10));
         random_items(20, 8);
         drain();
      end

      repeat (20) @(posedge clock);
      if (errors == 0) $display("** unit_augment_max_flow_engine: PASSED **");
      else $display("** unit_augment_max_flow_engine: FAILED **");
      $finish;
   end

   initial begin
      #100000000;
      $display("** unit_augment_max_flow_engine: FAILED **");
      $finish;
   end

endmodule
